@@ hw/rtl/cac_pkg.sv @@
package cac_pkg;

  // Data format
  localparam int DATA_WIDTH = 24;
  localparam int FRAC_BITS  = 16;

  // Derived widths
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int SUM_W   = PROD_W + 1;
  localparam int QUO_W   = DATA_WIDTH + 1;
  localparam int SHIFT   = QUO_W - FRAC_BITS - 1;
  localparam int MAG_W   = PROD_W - FRAC_BITS;
  localparam int LIMIT_W = DATA_WIDTH - 1;
  localparam int NUM_CELLS = QUO_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100 << FRAC_BITS);
  localparam logic [MAG_W-1:0]   MAG_TOP     = MAG_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(64'd1 << (FRAC_BITS - 1));

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_RANGE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  // One result component on its way through the divider chain
  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  dvd;
    logic [QUO_W-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              dz;
    logic [PROD_W-1:0] dsr;
    lane_t             re;
    lane_t             im;
  } stage_t;

endpackage

@@ hw/rtl/cac_if.sv @@
interface cac_in_if import cac_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [DATA_WIDTH-1:0] a_real;
  logic signed [DATA_WIDTH-1:0] a_imag;
  logic signed [DATA_WIDTH-1:0] b_real;
  logic signed [DATA_WIDTH-1:0] b_imag;

  modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cac_out_if import cac_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_real;
  logic signed [DATA_WIDTH-1:0] res_imag;
  logic                         div_zero;

  modport source (output valid, res_real, res_imag, div_zero, input ready);
  modport sink   (input valid, res_real, res_imag, div_zero, output ready);
endinterface

@@ hw/rtl/cac_front.sv @@
module cac_front import cac_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [1:0]                   command_i,
  input  logic signed [DATA_WIDTH-1:0] a_real_i,
  input  logic signed [DATA_WIDTH-1:0] a_imag_i,
  input  logic signed [DATA_WIDTH-1:0] b_real_i,
  input  logic signed [DATA_WIDTH-1:0] b_imag_i,
  output stage_t                       stage_o
);

  // Stage 1: products and add/subtract
  logic                    v1_q;
  cmd_e                    cmd1_q;
  logic signed [PROD_W-1:0] rr_q, ii_q, ri_q, ir_q, sr_q, si_q;
  logic signed [DATA_WIDTH:0] as_re_q, as_im_q;
  logic signed [DATA_WIDTH:0] as_re_d, as_im_d;

  always_comb begin
    if (cmd_e'(command_i) == CMD_SUB) begin
      as_re_d = {a_real_i[DATA_WIDTH-1], a_real_i} - {b_real_i[DATA_WIDTH-1], b_real_i};
      as_im_d = {a_imag_i[DATA_WIDTH-1], a_imag_i} - {b_imag_i[DATA_WIDTH-1], b_imag_i};
    end else begin
      as_re_d = {a_real_i[DATA_WIDTH-1], a_real_i} + {b_real_i[DATA_WIDTH-1], b_real_i};
      as_im_d = {a_imag_i[DATA_WIDTH-1], a_imag_i} + {b_imag_i[DATA_WIDTH-1], b_imag_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q  <= cmd_e'(command_i);
      rr_q    <= PROD_W'(a_real_i) * PROD_W'(b_real_i);
      ii_q    <= PROD_W'(a_imag_i) * PROD_W'(b_imag_i);
      ri_q    <= PROD_W'(a_real_i) * PROD_W'(b_imag_i);
      ir_q    <= PROD_W'(a_imag_i) * PROD_W'(b_real_i);
      sr_q    <= PROD_W'(b_real_i) * PROD_W'(b_real_i);
      si_q    <= PROD_W'(b_imag_i) * PROD_W'(b_imag_i);
      as_re_q <= as_re_d;
      as_im_q <= as_im_d;
    end
  end

  // Stage 2: combine products
  logic                    v2_q;
  cmd_e                    cmd2_q;
  logic signed [SUM_W-1:0] mre_q, mim_q, nre_q, nim_q;
  logic [PROD_W-1:0]       dsr_q;
  logic signed [DATA_WIDTH:0] as_re2_q, as_im2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd2_q   <= cmd1_q;
      mre_q    <= {rr_q[PROD_W-1], rr_q} - {ii_q[PROD_W-1], ii_q};
      mim_q    <= {ri_q[PROD_W-1], ri_q} + {ir_q[PROD_W-1], ir_q};
      nre_q    <= {rr_q[PROD_W-1], rr_q} + {ii_q[PROD_W-1], ii_q};
      nim_q    <= {ir_q[PROD_W-1], ir_q} - {ri_q[PROD_W-1], ri_q};
      dsr_q    <= sr_q + si_q;
      as_re2_q <= as_re_q;
      as_im2_q <= as_im_q;
    end
  end

  // Stage 3: sign and magnitude, product rounding, divider setup
  logic [PROD_W-1:0] mm_re, mm_im, nm_re, nm_im;
  logic [PROD_W-1:0] p0_re, p0_im;
  stage_t            s3_d, s3_q;

  assign mm_re = mre_q[SUM_W-1] ? PROD_W'(-mre_q) : PROD_W'(mre_q);
  assign mm_im = mim_q[SUM_W-1] ? PROD_W'(-mim_q) : PROD_W'(mim_q);
  assign nm_re = nre_q[SUM_W-1] ? PROD_W'(-nre_q) : PROD_W'(nre_q);
  assign nm_im = nim_q[SUM_W-1] ? PROD_W'(-nim_q) : PROD_W'(nim_q);
  assign p0_re = nm_re >> SHIFT;
  assign p0_im = nm_im >> SHIFT;

  always_comb begin
    s3_d        = '0;
    s3_d.valid  = v2_q;
    s3_d.is_div = (cmd2_q == CMD_DIV);
    s3_d.dz     = (cmd2_q == CMD_DIV) && (dsr_q == '0);
    s3_d.dsr    = dsr_q;
    case (cmd2_q)
      CMD_ADD, CMD_SUB: begin
        s3_d.re.neg = as_re2_q[DATA_WIDTH];
        s3_d.im.neg = as_im2_q[DATA_WIDTH];
        s3_d.re.mag = as_re2_q[DATA_WIDTH] ? MAG_W'(-as_re2_q) : MAG_W'(as_re2_q);
        s3_d.im.mag = as_im2_q[DATA_WIDTH] ? MAG_W'(-as_im2_q) : MAG_W'(as_im2_q);
      end
      CMD_MUL: begin
        s3_d.re.neg = mre_q[SUM_W-1];
        s3_d.im.neg = mim_q[SUM_W-1];
        s3_d.re.mag = MAG_W'((mm_re + ROUND_HALF) >> FRAC_BITS);
        s3_d.im.mag = MAG_W'((mm_im + ROUND_HALF) >> FRAC_BITS);
      end
      default: begin
        s3_d.re.neg = nre_q[SUM_W-1];
        s3_d.im.neg = nim_q[SUM_W-1];
        s3_d.re.ovf = (p0_re >= dsr_q);
        s3_d.im.ovf = (p0_im >= dsr_q);
        s3_d.re.rem = p0_re;
        s3_d.im.rem = p0_im;
        s3_d.re.dvd = {nm_re[SHIFT-1:0], (FRAC_BITS + 1)'(0)};
        s3_d.im.dvd = {nm_im[SHIFT-1:0], (FRAC_BITS + 1)'(0)};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en_i) begin
      s3_q <= s3_d;
    end
  end

  assign stage_o = s3_q;

endmodule

@@ hw/rtl/cac_cell.sv @@
module cac_cell import cac_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  stage_t stage_i,
  output stage_t stage_o
);

  logic [PROD_W:0] t_re, t_im, dx;
  logic            ge_re, ge_im;
  stage_t          st_d, st_q;

  // One restoring division step on both lanes
  assign dx    = {1'b0, stage_i.dsr};
  assign t_re  = {stage_i.re.rem, stage_i.re.dvd[QUO_W-1]};
  assign t_im  = {stage_i.im.rem, stage_i.im.dvd[QUO_W-1]};
  assign ge_re = (t_re >= dx);
  assign ge_im = (t_im >= dx);

  always_comb begin
    st_d        = stage_i;
    st_d.re.rem = ge_re ? PROD_W'(t_re - dx) : t_re[PROD_W-1:0];
    st_d.im.rem = ge_im ? PROD_W'(t_im - dx) : t_im[PROD_W-1:0];
    st_d.re.dvd = {stage_i.re.dvd[QUO_W-2:0], 1'b0};
    st_d.im.dvd = {stage_i.im.dvd[QUO_W-2:0], 1'b0};
    st_d.re.quo = {stage_i.re.quo[QUO_W-2:0], ge_re};
    st_d.im.quo = {stage_i.im.quo[QUO_W-2:0], ge_im};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;

endmodule

@@ hw/rtl/cac_back.sv @@
module cac_back import cac_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  stage_t                       stage_i,
  input  logic [LIMIT_W-1:0]           limit_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] res_real_o,
  output logic signed [DATA_WIDTH-1:0] res_imag_o,
  output logic                         div_zero_o
);

  logic [QUO_W-1:0]      qr_re, qr_im;
  logic [MAG_W-1:0]      mag_re, mag_im;
  logic                  drop_re, drop_im;
  logic [DATA_WIDTH-1:0] val_re, val_im;
  logic                  valid_q, dz_q;
  logic [DATA_WIDTH-1:0] re_q, im_q;

  // Round the quotient half away from zero
  assign qr_re = QUO_W'(({1'b0, stage_i.re.quo} + (QUO_W + 1)'(1)) >> 1);
  assign qr_im = QUO_W'(({1'b0, stage_i.im.quo} + (QUO_W + 1)'(1)) >> 1);

  assign mag_re = stage_i.is_div ? MAG_W'(qr_re) : stage_i.re.mag;
  assign mag_im = stage_i.is_div ? MAG_W'(qr_im) : stage_i.im.mag;

  // Drop components beyond the limit or the data range, and both on a zero divisor
  assign drop_re = stage_i.re.ovf || stage_i.dz || (mag_re > MAG_W'(limit_i)) ||
                   (mag_re > MAG_TOP);
  assign drop_im = stage_i.im.ovf || stage_i.dz || (mag_im > MAG_W'(limit_i)) ||
                   (mag_im > MAG_TOP);

  assign val_re = drop_re ? '0 :
                  (stage_i.re.neg ? DATA_WIDTH'(-mag_re) : DATA_WIDTH'(mag_re));
  assign val_im = drop_im ? '0 :
                  (stage_i.im.neg ? DATA_WIDTH'(-mag_im) : DATA_WIDTH'(mag_im));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q <= val_re;
      im_q <= val_im;
      dz_q <= stage_i.dz;
    end
  end

  assign valid_o    = valid_q;
  assign res_real_o = re_q;
  assign res_imag_o = im_q;
  assign div_zero_o = dz_q;

endmodule

@@ hw/rtl/complex_arithmetic_clamped_core.sv @@
// Complex add/subtract/multiply/divide on signed fixed point, range-limited.
// Pipeline: 3 setup stages, then one divider cell per quotient bit, 25 cells,
// then the output register.
// Throughput: one item per cycle; the whole pipeline holds only while a result waits.
// Reset: asynchronous active low; empties the pipeline and sets the limit to 100.0.
module complex_arithmetic_clamped_core import cac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cac_in_if.sink                in_i,
  cac_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic               en;
  logic [LIMIT_W-1:0] limit_q;
  stage_t             chain [NUM_CELLS+1];

  // Advance the pipeline unless a result is stuck at the output
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RANGE_LIMIT) ? APB_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RANGE_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  cac_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .command_i (in_i.command),
    .a_real_i  (in_i.a_real),
    .a_imag_i  (in_i.a_imag),
    .b_real_i  (in_i.b_real),
    .b_imag_i  (in_i.b_imag),
    .stage_o   (chain[0])
  );

  // Divider chain: one quotient bit per cell
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    cac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  cac_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .stage_i    (chain[NUM_CELLS]),
    .limit_i    (limit_q),
    .valid_o    (out_o.valid),
    .res_real_o (out_o.res_real),
    .res_imag_o (out_o.res_imag),
    .div_zero_o (out_o.div_zero)
  );

endmodule
